>>> src/alfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared types and constants for the additive lagged Fibonacci generator.
// ----------------------------------------------------------------------------
package alfp_pkg;

  localparam int unsigned DEGREE     = 31;
  localparam int unsigned SEPARATION = 3;
  localparam int unsigned DISCARDS   = 10 * DEGREE;
  localparam int unsigned IDX_W      = $clog2(DEGREE);
  localparam int unsigned DCNT_W     = $clog2(DISCARDS);

  localparam logic [14:0] LEHMER_A  = 15'd16807;
  localparam logic [16:0] SCHRAGE_Q = 17'd127773;
  localparam logic [11:0] SCHRAGE_R = 12'd2836;
  localparam logic [30:0] LEHMER_M  = 31'h7fffffff;

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_DRAW31 = 2'd1;
  localparam logic [1:0] OP_DRAW32 = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_RED,
    ST_FIX,
    ST_RD,
    ST_ADD
  } state_t;

  typedef enum logic [1:0] {
    MD_DRAW31,
    MD_DRAW32A,
    MD_DRAW32B,
    MD_DISCARD
  } mode_t;

  function automatic idx_t idx_inc(input idx_t i);
    idx_inc = (i == idx_t'(DEGREE - 1)) ? '0 : i + idx_t'(1);
  endfunction

endpackage

>>> src/additive_lagged_fibonacci_prng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_prng
// 31-word additive feedback generator (taps 31 and 3) with Lehmer reseed.
// ----------------------------------------------------------------------------
// One request at a time. A draw31 is a registered read of the front and rear
// words followed by one add and write-back through the single table write
// port, and a draw32 is two such read-add steps. A reseed gives no result:
// the seed word is stored, then each of the 30 Lehmer steps runs a multiply
// of the word magnitude by 16807, a fold of the product modulo 2^31-1 and a
// final compare-subtract and sign correction, then 310 draws are discarded.
// Until the first reseed the table reads as zeros, so draws return 0.
module additive_lagged_fibonacci_prng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] value
);
  import alfp_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [31:0] mem [DEGREE];
  logic [DEGREE-1:0] valid_r;

  idx_t front_r, front_nxt;
  idx_t rear_r, rear_nxt;
  idx_t step_r, step_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic [31:0] rd_f_r, rd_r_r;
  logic [15:0] first_r, first_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] word_r, word_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [46:0] prod_r, prod_nxt;
  logic [31:0] red_r, red_nxt;

  logic        wr_en;
  idx_t        wr_addr;
  logic [31:0] wr_data;

  logic        in_acc;
  logic        out_free;
  logic        final_draw;
  logic [31:0] sum;
  logic [31:0] fold;
  logic [31:0] fixed;
  logic [31:0] load_word;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_free   = !out_valid_r || out_tready;
  assign final_draw = (mode_r == MD_DRAW31) || (mode_r == MD_DRAW32B);
  assign sum        = rd_f_r + rd_r_r;
  assign fold       = (red_r >= {1'b0, LEHMER_M}) ? red_r - {1'b0, LEHMER_M} : red_r;
  assign fixed      = (neg_r && fold != 32'd0) ? {1'b0, LEHMER_M} - fold : fold;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser) inside
            OP_RESEED: state_nxt = ST_SEED;
            OP_DRAW31, OP_DRAW32: state_nxt = ST_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEED: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = (step_r == idx_t'(DEGREE - 1)) ? ST_RD : ST_MUL;
      ST_RD:   if (!final_draw || out_free) state_nxt = ST_ADD;
      ST_ADD: begin
        if (mode_r == MD_DRAW32A) begin
          state_nxt = ST_RD;
        end else if (mode_r == MD_DISCARD) begin
          state_nxt = (dcnt_r == DCNT_W'(DISCARDS - 1)) ? ST_IDLE : ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt      = mode_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    step_nxt      = step_r;
    dcnt_nxt      = dcnt_r;
    first_nxt     = first_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_tready;
    word_nxt      = word_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    red_nxt       = red_r;
    wr_en         = 1'b0;
    wr_addr       = step_r;
    wr_data       = word_r;
    load_word     = word_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = (in_tuser == OP_DRAW32) ? MD_DRAW32A : MD_DRAW31;
          word_nxt = (in_tdata == 32'd0) ? 32'd1 : in_tdata;
        end
      end
      ST_SEED: begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        step_nxt = idx_t'(1);
      end
      ST_MUL: begin
        prod_nxt = {32'd0, LEHMER_A} * {15'd0, mag_r};
      end
      ST_RED: begin
        // 2^31 is 1 modulo 2^31-1
        red_nxt = {1'b0, prod_r[30:0]} + {16'd0, prod_r[46:31]};
      end
      ST_FIX: begin
        word_nxt  = fixed;
        load_word = fixed;
        wr_en     = 1'b1;
        wr_data   = fixed;
        step_nxt  = step_r + idx_t'(1);
        if (step_r == idx_t'(DEGREE - 1)) begin
          front_nxt = idx_t'(SEPARATION);
          rear_nxt  = '0;
          dcnt_nxt  = '0;
          mode_nxt  = MD_DISCARD;
        end
      end
      ST_RD: begin
      end
      ST_ADD: begin
        wr_en     = 1'b1;
        wr_addr   = front_r;
        wr_data   = sum;
        front_nxt = idx_inc(front_r);
        rear_nxt  = idx_inc(rear_r);
        unique case (mode_r)
          MD_DRAW31: begin
            out_value_nxt = {1'b0, sum[31:1]};
            out_valid_nxt = 1'b1;
          end
          MD_DRAW32A: begin
            first_nxt = sum[16:1];
            mode_nxt  = MD_DRAW32B;
          end
          MD_DRAW32B: begin
            out_value_nxt = {first_r, sum[16:1]};
            out_valid_nxt = 1'b1;
          end
          MD_DISCARD: dcnt_nxt = dcnt_r + DCNT_W'(1);
          default: ;
        endcase
      end
      default: ;
    endcase

    // operand load for the next Lehmer step
    if (state_r == ST_SEED || state_r == ST_FIX) begin
      neg_nxt = load_word[31];
      mag_nxt = load_word[31] ? (~load_word + 32'd1) : load_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MD_DRAW31;
      valid_r     <= '0;
      front_r     <= idx_t'(SEPARATION);
      rear_r      <= '0;
      step_r      <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      step_r      <= step_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    out_value_r <= out_value_nxt;
    word_r      <= word_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    prod_r      <= prod_nxt;
    red_r       <= red_nxt;
  end

  // feedback table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_r == ST_RD) begin
      rd_f_r <= valid_r[front_r] ? mem[front_r] : 32'd0;
      rd_r_r <= valid_r[rear_r] ? mem[rear_r] : 32'd0;
    end
  end

endmodule
